// File: rtl/matrix4_inverse_assert.svh
// ----------------------------------------------------------------------------
// matrix4_inverse assertion macros
// concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef MATRIX4_INVERSE_ASSERT_SVH
`define MATRIX4_INVERSE_ASSERT_SVH

`ifndef ASSERT_OFF
// implication checked on every clock edge outside reset
`define M4I_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// condition that must never be true outside reset
`define M4I_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
// next-cycle implication outside reset
`define M4I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define M4I_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define M4I_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define M4I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/m4i_pkg.sv
// ----------------------------------------------------------------------------
// m4i_pkg
// shared constants, command and status types, cofactor address helpers
// ----------------------------------------------------------------------------
package m4i_pkg;

    localparam int ELEMENT_WIDTH_DEF = 16;
    localparam int OUT_WIDTH_DEF     = 32;
    localparam int ACC_W             = 64;
    localparam int KEEP_SHIFT        = 12;
    localparam int INV_SHIFT         = 16;
    localparam int IDX_W             = 4;
    localparam int TERM_W            = 3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [TERM_W-1:0] term_t;

    typedef struct packed {
        logic mat_we;
        idx_t mat_waddr;
        logic mat_re;
        idx_t mat_raddr;
        logic cof_re;
        idx_t cof_raddr;
        logic cof_we;
        idx_t cof_waddr;
        logic opa_from_mat;
        logic opa_from_prod;
        logic mul_start;
        logic mul_det;
        logic acc_clr;
        logic acc_add;
        logic acc_sub;
        logic det_we;
        logic div_start;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic singular;
    } dp_sts_t;

    // column pick of each 3x3 permutation term, slot 0..2
    function automatic logic [1:0] perm_col(input term_t term, input logic [1:0] slot);
        logic [5:0] p;
        case (term)
            3'd0:    p = 6'b00_01_10;
            3'd1:    p = 6'b01_10_00;
            3'd2:    p = 6'b10_00_01;
            3'd3:    p = 6'b00_10_01;
            3'd4:    p = 6'b01_00_10;
            3'd5:    p = 6'b10_01_00;
            default: p = 6'b00_01_10;
        endcase
        case (slot)
            2'd0:    perm_col = p[5:4];
            2'd1:    perm_col = p[3:2];
            default: perm_col = p[1:0];
        endcase
    endfunction

    // element address for adjugate entry cidx, term, slot
    function automatic idx_t term_addr(input idx_t cidx, input term_t term,
                                       input logic [1:0] slot);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] s;
        logic [1:0] row;
        logic [1:0] col;
        r   = cidx[3:2];
        c   = cidx[1:0];
        s   = perm_col(term, slot);
        row = slot + {1'b0, (slot >= c)};
        col = s + {1'b0, (s >= r)};
        term_addr = {row, col};
    endfunction

    // odd permutation xor checkerboard sign
    function automatic logic term_neg(input idx_t cidx, input term_t term);
        term_neg = (term >= 3'd3) ^ cidx[2] ^ cidx[0];
    endfunction

endpackage

// File: rtl/m4i_mul.sv
// ----------------------------------------------------------------------------
// m4i_mul
// 64 by 64 multiply modulo 2^64 on one shared 32 by 32 multiplier, 3 steps
// ----------------------------------------------------------------------------
module m4i_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  m4i_pkg::acc_t       a,
    input  m4i_pkg::acc_t       b,
    output logic                done,
    output m4i_pkg::acc_t       prod
);

    localparam int AW   = m4i_pkg::ACC_W;
    localparam int HALF = AW / 2;

    m4i_pkg::acc_t a_reg, b_reg, p_reg, p_next;
    logic [1:0]    step_reg, step_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [HALF-1:0] x, y;
    logic [AW-1:0]   pp;

    always_comb
    begin
        case (step_reg)
            2'd0:    begin x = a_reg[HALF-1:0];  y = b_reg[HALF-1:0];  end
            2'd1:    begin x = a_reg[HALF-1:0];  y = b_reg[AW-1:HALF]; end
            default: begin x = a_reg[AW-1:HALF]; y = b_reg[HALF-1:0];  end
        endcase
        pp = x * y;
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd0)
            begin
                p_next = pp;
            end
            else
            begin
                p_next = p_reg + {pp[HALF-1:0], {HALF{1'b0}}};
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

// File: rtl/m4i_div.sv
// ----------------------------------------------------------------------------
// m4i_div
// signed 64 bit divide, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
module m4i_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  m4i_pkg::acc_t  num,
    input  m4i_pkg::acc_t  den,
    output logic           done,
    output logic           neg,
    output m4i_pkg::acc_t  qmag
);

    localparam int AW  = m4i_pkg::ACC_W;
    localparam int CW  = $clog2(AW);

    m4i_pkg::acc_t rem_reg, rem_next;
    m4i_pkg::acc_t quo_reg, quo_next;
    m4i_pkg::acc_t dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [AW:0]   trial;
    logic [AW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[AW-1]};
        diff      = trial - {1'b0, dmag_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num[AW-1] ? (~num + AW'(1)) : num;
            dmag_next = den[AW-1] ? (~den + AW'(1)) : den;
            neg_next  = num[AW-1] ^ den[AW-1];
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[AW] ? trial[AW-1:0] : diff[AW-1:0];
            quo_next = {quo_reg[AW-2:0], ~diff[AW]};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(AW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign qmag = quo_reg;

endmodule

// File: rtl/m4i_datapath.sv
// ----------------------------------------------------------------------------
// m4i_datapath
// element and cofactor stores, accumulator, determinant, output registers
// ----------------------------------------------------------------------------
module m4i_datapath #(
    parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF,
    parameter int OUT_WIDTH     = m4i_pkg::OUT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  m4i_pkg::dp_cmd_t            cmd,
    output m4i_pkg::dp_sts_t            sts,
    input  logic signed [ELEMENT_WIDTH-1:0] elem_value,
    output logic signed [OUT_WIDTH-1:0] inv_value,
    output logic                        saturated
);

    localparam int AW = m4i_pkg::ACC_W;
    localparam int DEPTH = 1 << m4i_pkg::IDX_W;
    localparam m4i_pkg::acc_t SAT_HI_MAG = (AW'(1) << (OUT_WIDTH - 1)) - AW'(1);
    localparam m4i_pkg::acc_t SAT_LO_MAG = AW'(1) << (OUT_WIDTH - 1);
    localparam logic [OUT_WIDTH-1:0] OUT_HI = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_LO = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    logic [ELEMENT_WIDTH-1:0] mat_store_reg [DEPTH];
    m4i_pkg::acc_t            cof_store_reg [DEPTH];
    logic [ELEMENT_WIDTH-1:0] mat_q_reg;
    m4i_pkg::acc_t            cof_q_reg;
    m4i_pkg::acc_t            opa_reg, opa_next;
    m4i_pkg::acc_t            acc_reg, acc_next;
    m4i_pkg::acc_t            det_reg, det_next;
    logic [OUT_WIDTH-1:0]     out_value_reg, out_value_next;
    logic                     out_sat_reg, out_sat_next;

    m4i_pkg::acc_t mat_ext, mul_a, mul_b, prod, qmag, qneg, qval, kept;
    logic          mul_done, div_done, div_neg, sat;

    assign mat_ext = {{(AW-ELEMENT_WIDTH){mat_q_reg[ELEMENT_WIDTH-1]}}, mat_q_reg};
    assign mul_a   = cmd.mul_det ? mat_ext : opa_reg;
    assign mul_b   = cmd.mul_det ? cof_q_reg : mat_ext;
    // floor to 24 fraction bits
    assign kept    = m4i_pkg::acc_t'($signed(acc_reg) >>> m4i_pkg::KEEP_SHIFT);

    m4i_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    m4i_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (cof_q_reg << m4i_pkg::INV_SHIFT),
        .den   (det_reg),
        .done  (div_done),
        .neg   (div_neg),
        .qmag  (qmag)
    );

    // store memories
    always_ff @(posedge clk)
    begin
        if (cmd.mat_we)
        begin
            mat_store_reg[cmd.mat_waddr] <= elem_value;
        end
        if (cmd.mat_re)
        begin
            mat_q_reg <= mat_store_reg[cmd.mat_raddr];
        end
        if (cmd.cof_we)
        begin
            cof_store_reg[cmd.cof_waddr] <= kept;
        end
        if (cmd.cof_re)
        begin
            cof_q_reg <= cof_store_reg[cmd.cof_raddr];
        end
    end

    always_comb
    begin
        qneg = ~qmag + AW'(1);
        qval = div_neg ? qneg : qmag;
        sat  = div_neg ? (qmag > SAT_LO_MAG) : (qmag > SAT_HI_MAG);

        opa_next = opa_reg;
        if (cmd.opa_from_mat)
        begin
            opa_next = mat_ext;
        end
        else if (cmd.opa_from_prod)
        begin
            opa_next = prod;
        end

        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (cmd.acc_add)
        begin
            acc_next = acc_reg + prod;
        end
        else if (cmd.acc_sub)
        begin
            acc_next = acc_reg - prod;
        end

        det_next = cmd.det_we ? kept : det_reg;

        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        if (cmd.out_load)
        begin
            if (sts.singular)
            begin
                out_value_next = '0;
                out_sat_next   = 1'b0;
            end
            else if (sat)
            begin
                out_value_next = div_neg ? OUT_LO : OUT_HI;
                out_sat_next   = 1'b1;
            end
            else
            begin
                out_value_next = qval[OUT_WIDTH-1:0];
                out_sat_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_reg <= '0;
        end
        else
        begin
            det_reg <= det_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg       <= opa_next;
        acc_reg       <= acc_next;
        out_value_reg <= out_value_next;
        out_sat_reg   <= out_sat_next;
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.singular = (det_reg == '0);
    assign inv_value    = out_value_reg;
    assign saturated    = out_sat_reg;

endmodule

// File: rtl/m4i_ctrl.sv
// ----------------------------------------------------------------------------
// m4i_ctrl
// sequencer for load, cofactor terms, determinant and per element divide
// ----------------------------------------------------------------------------
module m4i_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              last,
    output m4i_pkg::dp_cmd_t  cmd,
    input  m4i_pkg::dp_sts_t  sts
);

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_T_RD0  = 5'd1;
    localparam logic [4:0] S_T_RD1  = 5'd2;
    localparam logic [4:0] S_T_MUL1 = 5'd3;
    localparam logic [4:0] S_T_W1   = 5'd4;
    localparam logic [4:0] S_T_MUL2 = 5'd5;
    localparam logic [4:0] S_T_W2   = 5'd6;
    localparam logic [4:0] S_COF_WR = 5'd7;
    localparam logic [4:0] S_D_RD   = 5'd8;
    localparam logic [4:0] S_D_MUL  = 5'd9;
    localparam logic [4:0] S_D_W    = 5'd10;
    localparam logic [4:0] S_D_WR   = 5'd11;
    localparam logic [4:0] S_Q_RD   = 5'd12;
    localparam logic [4:0] S_Q_DIV  = 5'd13;
    localparam logic [4:0] S_Q_W    = 5'd14;
    localparam logic [4:0] S_Q_OUT  = 5'd15;

    localparam m4i_pkg::idx_t  IDX_LAST  = '1;
    localparam m4i_pkg::term_t TERM_LAST = 3'd5;

    logic [4:0]     state_reg, state_next;
    m4i_pkg::idx_t  load_reg, load_next;
    m4i_pkg::idx_t  cidx_reg, cidx_next;
    m4i_pkg::term_t term_reg, term_next;
    logic [1:0]     dslot_reg, dslot_next;

    always_comb
    begin
        state_next = state_reg;
        load_next  = load_reg;
        cidx_next  = cidx_reg;
        term_next  = term_reg;
        dslot_next = dslot_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.mat_we    = 1'b1;
                    cmd.mat_waddr = load_reg;
                    if (load_reg == IDX_LAST)
                    begin
                        load_next   = '0;
                        cidx_next   = '0;
                        term_next   = '0;
                        cmd.acc_clr = 1'b1;
                        state_next  = S_T_RD0;
                    end
                    else
                    begin
                        load_next = load_reg + 1'b1;
                    end
                end
            end
            S_T_RD0:
            begin
                cmd.mat_re    = 1'b1;
                cmd.mat_raddr = m4i_pkg::term_addr(cidx_reg, term_reg, 2'd0);
                state_next    = S_T_RD1;
            end
            S_T_RD1:
            begin
                cmd.mat_re       = 1'b1;
                cmd.mat_raddr    = m4i_pkg::term_addr(cidx_reg, term_reg, 2'd1);
                cmd.opa_from_mat = 1'b1;
                state_next       = S_T_MUL1;
            end
            S_T_MUL1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mat_re    = 1'b1;
                cmd.mat_raddr = m4i_pkg::term_addr(cidx_reg, term_reg, 2'd2);
                state_next    = S_T_W1;
            end
            S_T_W1:
            begin
                if (sts.mul_done)
                begin
                    cmd.opa_from_prod = 1'b1;
                    state_next        = S_T_MUL2;
                end
            end
            S_T_MUL2:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_T_W2;
            end
            S_T_W2:
            begin
                if (sts.mul_done)
                begin
                    if (m4i_pkg::term_neg(cidx_reg, term_reg))
                    begin
                        cmd.acc_sub = 1'b1;
                    end
                    else
                    begin
                        cmd.acc_add = 1'b1;
                    end
                    if (term_reg == TERM_LAST)
                    begin
                        state_next = S_COF_WR;
                    end
                    else
                    begin
                        term_next  = term_reg + 1'b1;
                        state_next = S_T_RD0;
                    end
                end
            end
            S_COF_WR:
            begin
                cmd.cof_we    = 1'b1;
                cmd.cof_waddr = cidx_reg;
                cmd.acc_clr   = 1'b1;
                term_next     = '0;
                if (cidx_reg == IDX_LAST)
                begin
                    cidx_next  = '0;
                    dslot_next = '0;
                    state_next = S_D_RD;
                end
                else
                begin
                    cidx_next  = cidx_reg + 1'b1;
                    state_next = S_T_RD0;
                end
            end
            S_D_RD:
            begin
                cmd.mat_re    = 1'b1;
                cmd.mat_raddr = {2'b00, dslot_reg};
                cmd.cof_re    = 1'b1;
                cmd.cof_raddr = {dslot_reg, 2'b00};
                state_next    = S_D_MUL;
            end
            S_D_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_det   = 1'b1;
                state_next    = S_D_W;
            end
            S_D_W:
            begin
                if (sts.mul_done)
                begin
                    cmd.acc_add = 1'b1;
                    if (dslot_reg == 2'd3)
                    begin
                        state_next = S_D_WR;
                    end
                    else
                    begin
                        dslot_next = dslot_reg + 2'd1;
                        state_next = S_D_RD;
                    end
                end
            end
            S_D_WR:
            begin
                cmd.det_we = 1'b1;
                cidx_next  = '0;
                state_next = S_Q_RD;
            end
            S_Q_RD:
            begin
                cmd.cof_re    = 1'b1;
                cmd.cof_raddr = cidx_reg;
                state_next    = S_Q_DIV;
            end
            S_Q_DIV:
            begin
                if (sts.singular)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_Q_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_Q_W;
                end
            end
            S_Q_W:
            begin
                if (sts.div_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_Q_OUT;
                end
            end
            S_Q_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (cidx_reg == IDX_LAST)
                    begin
                        cidx_next  = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cidx_next  = cidx_reg + 1'b1;
                        state_next = S_Q_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            load_reg  <= '0;
            cidx_reg  <= '0;
            term_reg  <= '0;
            dslot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg  <= load_next;
            cidx_reg  <= cidx_next;
            term_reg  <= term_next;
            dslot_reg <= dslot_next;
        end
    end

    assign last = (state_reg == S_Q_OUT) && (cidx_reg == IDX_LAST);

endmodule

// File: rtl/matrix4_inverse.sv
// order: after the sixteenth element transfer come the cofactor pass, the determinant pass
//   and then one divide and output per result
// throughput: one element per cycle while loading; each result waits on the 64 step
//   restoring divider (not started when singular); cofactors use the shared 3 step
//   multiplier (12 products per cofactor); the next matrix loads after the last result
// reset: asynchronous active low, clears the sequencer, counters and determinant
// ----------------------------------------------------------------------------
// matrix4_inverse
// 4x4 fixed point inverse by cofactors, Q4.12 in, Q16.16 out, saturating
// ----------------------------------------------------------------------------
`include "matrix4_inverse_assert.svh"

module matrix4_inverse #(
    parameter int ELEMENT_WIDTH = m4i_pkg::ELEMENT_WIDTH_DEF,
    parameter int OUT_WIDTH     = m4i_pkg::OUT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // element channel, one transfer per matrix element in storage order
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [ELEMENT_WIDTH-1:0] elem_value,
    // result channel, sixteen transfers per matrix
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [OUT_WIDTH-1:0]     inv_value,
    output logic                            singular,
    output logic                            saturated,
    output logic                            last
);

    // command and status between sequencer and datapath
    m4i_pkg::dp_cmd_t cmd;
    m4i_pkg::dp_sts_t sts;

    // sequencer: load count, term and cofactor counters, output handshake
    m4i_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last      (last),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: stores, multiplier, accumulator, divider, output register
    m4i_datapath #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .OUT_WIDTH     (OUT_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .elem_value (elem_value),
        .inv_value  (inv_value),
        .saturated  (saturated)
    );

    // singular flag follows the kept determinant, stable through the result run
    assign singular = sts.singular;

    // no element transfer while a result is offered
    `M4I_ASSERT_NEVER(a_no_overlap, clk, rst_n, out_valid && !in_stall, "input open during output")
    // last result transfer returns the block to loading
    `M4I_ASSERT_NEXT(a_last_reload, clk, rst_n, out_valid && !out_stall && last, !in_stall, "no reload after last")
    // singular matrix gives clean zeros
    `M4I_ASSERT_IMPL(a_sing_zero, clk, rst_n, out_valid && singular, inv_value == '0 && !saturated, "singular output not zero")
    // divider never started on a zero determinant
    `M4I_ASSERT_IMPL(a_div_nonzero, clk, rst_n, cmd.div_start, !sts.singular, "divide by zero started")

endmodule
